// ===== design/mips_integer_execute_unit_top_macros.svh =====
// Assertion macros shared by the execute unit.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_TOP_MACROS_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MIE_ASSERT(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("execute unit check failed");
`define MIE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("execute unit check failed");
`else
`define MIE_ASSERT(lbl, clk, rstn, expr)
`define MIE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/mie_pkg.sv =====
package mie_pkg;

	localparam logic [2:0] FAULT_NONE     = 3'd0;
	localparam logic [2:0] FAULT_OVERFLOW = 3'd1;
	localparam logic [2:0] FAULT_ILLEGAL  = 3'd2;
	localparam logic [2:0] FAULT_SYSCALL  = 3'd3;
	localparam logic [2:0] FAULT_BREAK    = 3'd4;

	localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

	typedef enum logic [4:0] {
		OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV,
		OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO,
		OP_MULT, OP_MULTU, OP_DIV, OP_DIVU,
		OP_ADD, OP_ADDU, OP_SUB, OP_SUBU,
		OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU,
		OP_LUI, OP_FAULT
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  dest;
		logic        use_imm;
		logic [31:0] imm;
		logic [4:0]  sa;
		logic [2:0]  fault;
	} dec_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_DONE
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

// ===== design/mips_integer_execute_unit_top.sv =====
// The back end takes one instruction at a time: pops it in IDLE, executes in EXEC,
// goes through MUL for mult/multu or waits in DIV on the one-bit-per-cycle divider,
// then loads the output in DONE unless out_stall holds it, and returns to IDLE.
// The front decoder and queue keep accepting while the back end works, unless full.
// Reset (arst_n low, asynchronous) clears control, register valid bits, HI and LO.
module mips_integer_execute_unit_top
	import mie_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_enable,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic [2:0]  fault_code
);

	logic     full;
	logic     empty;
	logic     push;
	logic     pop;
	dec_t     dec;
	dec_t     head;
	div_req_t div_req;
	div_rsp_t div_rsp;

	mie_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.instr_word (instr_word),
		.full       (full),
		.push       (push),
		.dec        (dec)
	);

	mie_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	mie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mie_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_enable (write_enable),
		.dest_index   (dest_index),
		.dest_value   (dest_value),
		.fault_code   (fault_code)
	);

endmodule

// ===== design/mie_front.sv =====
module mie_front
	import mie_pkg::*;
(
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	input  logic        full,
	output logic        push,
	output dec_t        dec
);

	localparam logic [5:0] OPC_SPECIAL = 6'h00;
	localparam logic [5:0] OPC_ADDI    = 6'h08;
	localparam logic [5:0] OPC_ADDIU   = 6'h09;
	localparam logic [5:0] OPC_SLTI    = 6'h0a;
	localparam logic [5:0] OPC_SLTIU   = 6'h0b;
	localparam logic [5:0] OPC_ANDI    = 6'h0c;
	localparam logic [5:0] OPC_ORI     = 6'h0d;
	localparam logic [5:0] OPC_XORI    = 6'h0e;
	localparam logic [5:0] OPC_LUI     = 6'h0f;

	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_SYSCALL = 6'h0c;
	localparam logic [5:0] FN_BREAK   = 6'h0d;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1a;
	localparam logic [5:0] FN_DIVU    = 6'h1b;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2a;
	localparam logic [5:0] FN_SLTU    = 6'h2b;

	logic [5:0]  opc;
	logic [5:0]  fn;
	logic [15:0] imm16;
	logic [31:0] simm;
	logic [31:0] zimm;

	assign in_stall = full;
	assign push     = in_valid && !full;

	assign opc   = instr_word[31:26];
	assign fn    = instr_word[5:0];
	assign imm16 = instr_word[15:0];
	assign simm  = {{16{imm16[15]}}, imm16};
	assign zimm  = {16'h0000, imm16};

	always_comb begin
		dec.rs      = instr_word[25:21];
		dec.rt      = instr_word[20:16];
		dec.sa      = instr_word[10:6];
		dec.dest    = instr_word[15:11];
		dec.use_imm = 1'b0;
		dec.imm     = simm;
		dec.fault   = FAULT_NONE;
		dec.op      = OP_FAULT;
		if (opc == OPC_SPECIAL) begin
			case (fn)
				FN_SLL:     dec.op = OP_SLL;
				FN_SRL:     dec.op = OP_SRL;
				FN_SRA:     dec.op = OP_SRA;
				FN_SLLV:    dec.op = OP_SLLV;
				FN_SRLV:    dec.op = OP_SRLV;
				FN_SRAV:    dec.op = OP_SRAV;
				FN_SYSCALL: dec.fault = FAULT_SYSCALL;
				FN_BREAK:   dec.fault = FAULT_BREAK;
				FN_MFHI:    dec.op = OP_MFHI;
				FN_MTHI:    dec.op = OP_MTHI;
				FN_MFLO:    dec.op = OP_MFLO;
				FN_MTLO:    dec.op = OP_MTLO;
				FN_MULT:    dec.op = OP_MULT;
				FN_MULTU:   dec.op = OP_MULTU;
				FN_DIV:     dec.op = OP_DIV;
				FN_DIVU:    dec.op = OP_DIVU;
				FN_ADD:     dec.op = OP_ADD;
				FN_ADDU:    dec.op = OP_ADDU;
				FN_SUB:     dec.op = OP_SUB;
				FN_SUBU:    dec.op = OP_SUBU;
				FN_AND:     dec.op = OP_AND;
				FN_OR:      dec.op = OP_OR;
				FN_XOR:     dec.op = OP_XOR;
				FN_NOR:     dec.op = OP_NOR;
				FN_SLT:     dec.op = OP_SLT;
				FN_SLTU:    dec.op = OP_SLTU;
				default:    dec.fault = FAULT_ILLEGAL;
			endcase
		end else begin
			dec.dest    = instr_word[20:16];
			dec.use_imm = 1'b1;
			case (opc)
				OPC_ADDI:  dec.op = OP_ADD;
				OPC_ADDIU: dec.op = OP_ADDU;
				OPC_SLTI:  dec.op = OP_SLT;
				OPC_SLTIU: dec.op = OP_SLTU;
				OPC_ANDI: begin
					dec.op  = OP_AND;
					dec.imm = zimm;
				end
				OPC_ORI: begin
					dec.op  = OP_OR;
					dec.imm = zimm;
				end
				OPC_XORI: begin
					dec.op  = OP_XOR;
					dec.imm = zimm;
				end
				OPC_LUI: begin
					dec.op  = OP_LUI;
					dec.imm = {imm16, 16'h0000};
				end
				default: dec.fault = FAULT_ILLEGAL;
			endcase
		end
	end

endmodule

// ===== design/mie_fifo.sv =====
module mie_fifo
	import mie_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t wdata,
	input  logic pop,
	output dec_t rdata,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	dec_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/mie_div.sv =====
module mie_div
	import mie_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, den_q};

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/mie_back.sv =====
`include "mips_integer_execute_unit_top_macros.svh"
module mie_back
	import mie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  dec_t        head,
	output logic        pop,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_enable,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic [2:0]  fault_code
);

	state_t      state_q;
	state_t      state_d;
	dec_t        cur_q;
	logic [31:0] regs_q [32];
	logic [31:0] vld_q;
	logic [31:0] rda_q;
	logic [31:0] rdb_q;
	logic        va_q;
	logic        vb_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [63:0] prod_q;
	logic        neg_q_q;
	logic        neg_r_q;
	logic        res_we_q;
	logic [4:0]  res_idx_q;
	logic [31:0] res_val_q;
	logic [2:0]  res_fault_q;
	logic        out_valid_q;

	logic [31:0] a;
	logic [31:0] b;
	logic [4:0]  sh;
	logic [31:0] sum;
	logic [31:0] dif;
	logic [31:0] val;
	logic        writes;
	logic [2:0]  fault;
	logic        is_signed;
	logic [65:0] prod;
	logic        div_zero;
	logic        div_ovf;
	logic        reg_we;
	logic        load_out;
	logic        hilo_we;
	logic [31:0] hi_d;
	logic [31:0] lo_d;

	assign a  = va_q ? rda_q : '0;
	assign b  = cur_q.use_imm ? cur_q.imm : (vb_q ? rdb_q : '0);
	assign sh = (cur_q.op == OP_SLL || cur_q.op == OP_SRL || cur_q.op == OP_SRA) ?
		cur_q.sa : a[4:0];
	assign sum = a + b;
	assign dif = a - b;
	assign is_signed = (cur_q.op == OP_MULT) || (cur_q.op == OP_DIV);
	assign prod = $signed({is_signed & a[31], a}) * $signed({is_signed & b[31], b});
	assign div_zero = (b == '0);
	assign div_ovf  = (cur_q.op == OP_DIV) && (a == SIGN_BIT) && (b == ALL_ONES);

	always_comb begin
		val    = '0;
		writes = 1'b1;
		fault  = cur_q.fault;
		case (cur_q.op)
			OP_SLL, OP_SLLV: val = b << sh;
			OP_SRL, OP_SRLV: val = b >> sh;
			OP_SRA, OP_SRAV: val = 32'($signed(b) >>> sh);
			OP_MFHI:         val = hi_q;
			OP_MFLO:         val = lo_q;
			OP_ADD: begin
				val = sum;
				if (((a ^ sum) & (b ^ sum) & SIGN_BIT) != '0) begin
					writes = 1'b0;
					fault  = FAULT_OVERFLOW;
				end
			end
			OP_ADDU:         val = sum;
			OP_SUB: begin
				val = dif;
				if (((a ^ b) & (a ^ dif) & SIGN_BIT) != '0) begin
					writes = 1'b0;
					fault  = FAULT_OVERFLOW;
				end
			end
			OP_SUBU:         val = dif;
			OP_AND:          val = a & b;
			OP_OR:           val = a | b;
			OP_XOR:          val = a ^ b;
			OP_NOR:          val = ~(a | b);
			OP_SLT:          val = {31'd0, $signed(a) < $signed(b)};
			OP_SLTU:         val = {31'd0, a < b};
			OP_LUI:          val = b;
			default:         writes = 1'b0;
		endcase
		if (!writes || cur_q.dest == '0) begin
			writes = 1'b0;
			val    = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cur_q.op == OP_MULT || cur_q.op == OP_MULTU) begin
					state_d = ST_MUL;
				end else if ((cur_q.op == OP_DIV || cur_q.op == OP_DIVU) &&
					!div_zero && !div_ovf) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL: state_d = ST_DONE;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop           = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = a[31] && is_signed ? -a : a;
		div_req.den   = b[31] && is_signed ? -b : b;
		reg_we        = 1'b0;
		load_out      = 1'b0;
		hilo_we       = 1'b0;
		hi_d          = hi_q;
		lo_d          = lo_q;
		case (state_q)
			ST_IDLE: pop = !empty;
			ST_EXEC: begin
				reg_we = writes;
				case (cur_q.op)
					OP_MTHI: begin
						hilo_we = 1'b1;
						hi_d    = a;
					end
					OP_MTLO: begin
						hilo_we = 1'b1;
						lo_d    = a;
					end
					OP_DIV, OP_DIVU: begin
						if (div_zero) begin
							hilo_we = 1'b1;
							hi_d    = a;
							lo_d    = (is_signed && a[31]) ? 32'd1 : ALL_ONES;
						end else if (div_ovf) begin
							hilo_we = 1'b1;
							hi_d    = '0;
							lo_d    = SIGN_BIT;
						end else begin
							div_req.start = 1'b1;
						end
					end
					default: hilo_we = 1'b0;
				endcase
			end
			ST_MUL: begin
				hilo_we = 1'b1;
				hi_d    = prod_q[63:32];
				lo_d    = prod_q[31:0];
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					hilo_we = 1'b1;
					hi_d    = neg_r_q ? -div_rsp.rem : div_rsp.rem;
					lo_d    = neg_q_q ? -div_rsp.quo : div_rsp.quo;
				end
			end
			ST_DONE: load_out = !out_valid_q || !out_stall;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			rda_q <= regs_q[head.rs];
			rdb_q <= regs_q[head.rt];
		end
		if (reg_we) begin
			regs_q[cur_q.dest] <= val;
		end
		if (state_q == ST_EXEC) begin
			prod_q      <= prod[63:0];
			neg_q_q     <= is_signed && (a[31] != b[31]);
			neg_r_q     <= is_signed && a[31];
			res_we_q    <= writes;
			res_idx_q   <= writes ? cur_q.dest : '0;
			res_val_q   <= val;
			res_fault_q <= fault;
		end
		if (load_out) begin
			write_enable <= res_we_q;
			dest_index   <= res_idx_q;
			dest_value   <= res_val_q;
			fault_code   <= res_fault_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			va_q        <= 1'b0;
			vb_q        <= 1'b0;
			hi_q        <= '0;
			lo_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				va_q <= vld_q[head.rs];
				vb_q <= vld_q[head.rt];
			end
			if (reg_we) begin
				vld_q[cur_q.dest] <= 1'b1;
			end
			if (hilo_we) begin
				hi_q <= hi_d;
				lo_q <= lo_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`MIE_ASSERT_IMP(a_div_wait, clk, arst_n, state_q == ST_DIV, div_rsp.busy || div_rsp.done)
	`MIE_ASSERT_IMP(a_no_r0_write, clk, arst_n, reg_we, cur_q.dest != 5'd0)
	`MIE_ASSERT_IMP(a_load_free, clk, arst_n, load_out, !out_valid_q || !out_stall)
	`MIE_ASSERT(a_r0_invalid, clk, arst_n, !vld_q[0])
	`MIE_ASSERT_IMP(a_fault_no_write, clk, arst_n, out_valid_q && fault_code != FAULT_NONE,
		!write_enable)

endmodule
